### hdl/gpc_pkg.sv
// Shared types, register codes and pad line decoding for the gamepad I/O port controller.
package gpc_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	localparam logic [3:0] OFF_VERSION = 4'd0;
	localparam logic [3:0] OFF_DATA_A  = 4'd1;
	localparam logic [3:0] OFF_DATA_B  = 4'd2;
	localparam logic [3:0] OFF_DATA_C  = 4'd3;
	localparam logic [3:0] OFF_CTRL_A  = 4'd4;
	localparam logic [3:0] OFF_CTRL_B  = 4'd5;
	localparam logic [3:0] OFF_CTRL_C  = 4'd6;
	localparam logic [3:0] OFF_TX_0    = 4'd7;
	localparam logic [3:0] OFF_RX_0    = 4'd8;
	localparam logic [3:0] OFF_SCTL_0  = 4'd9;
	localparam logic [3:0] OFF_TX_1    = 4'd10;
	localparam logic [3:0] OFF_RX_1    = 4'd11;
	localparam logic [3:0] OFF_SCTL_1  = 4'd12;
	localparam logic [3:0] OFF_TX_2    = 4'd13;
	localparam logic [3:0] OFF_RX_2    = 4'd14;
	localparam logic [3:0] OFF_SCTL_2  = 4'd15;

	localparam logic [7:0] DATA_RESET   = 8'h7F;
	localparam logic [7:0] TX_0_RESET   = 8'hFF;
	localparam logic [7:0] TX_1_RESET   = 8'hFF;
	localparam logic [7:0] TX_2_RESET   = 8'hFB;
	localparam logic [7:0] VERSION_BASE = 8'h20;
	localparam logic [6:0] PORT_FILL    = 7'h7F;

	localparam logic [2:0] PHASE_MAX  = 3'd4;
	localparam logic [2:0] PHASE_LOW  = 3'd2;
	localparam logic [2:0] PHASE_HIGH = 3'd3;

	localparam int unsigned CFG_SIX_BUTTON = 0;
	localparam int unsigned CFG_REGION     = 1;

	typedef struct packed {
		logic       en;
		op_t        op;
		logic [3:0] offset;
		logic [7:0] wdata;
	} gpc_access_t;

	// Port A bits 6..0: TH on bit 6 and active-low pad lines below, chosen by TH, six-button mode and the pad phase.
	function automatic logic [6:0] pad_lines(
		input logic [11:0] b,
		input logic        th,
		input logic        six,
		input logic [2:0]  phase
	);
		logic [6:0] v;
		if (th) begin
			if (six && phase == PHASE_HIGH) begin
				v = {1'b1, ~b[6], ~b[5], ~b[11], ~b[8], ~b[9], ~b[10]};
			end else begin
				v = {1'b1, ~b[6], ~b[5], ~b[3], ~b[2], ~b[1], ~b[0]};
			end
		end else if (six && phase == PHASE_LOW) begin
			v = {1'b0, ~b[7], ~b[4], 4'b0000};
		end else if (six && phase == PHASE_HIGH) begin
			v = {1'b0, ~b[7], ~b[4], 4'b1111};
		end else begin
			v = {1'b0, ~b[7], ~b[4], 2'b00, ~b[1], ~b[0]};
		end
		return v;
	endfunction

endpackage

### hdl/gpc_regbank.sv
// Register bank, pad phase counter and read decoding of the gamepad I/O port controller.
module gpc_regbank (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gpc_pkg::gpc_access_t acc,
	input  logic [11:0]          buttons,
	input  logic                 six_button_mode,
	input  logic [7:0]           region_bits,
	output logic [7:0]           read_data
);
	import gpc_pkg::*;

	logic [7:0] data_a_q;
	logic [7:0] data_b_q;
	logic [7:0] data_c_q;
	logic [7:0] ctrl_a_q;
	logic [7:0] ctrl_b_q;
	logic [7:0] ctrl_c_q;
	logic [7:0] tx_q [3];
	logic [4:0] sctl_q [3];
	logic [2:0] phase_q;

	logic do_write;
	logic do_clear;
	logic phase_step;
	logic [7:0] rd_mux;

	assign do_write = acc.en && acc.op == OP_WRITE;
	assign do_clear = acc.en && acc.op == OP_CLEAR;
	assign phase_step = do_write && acc.offset == OFF_DATA_A && six_button_mode
		&& !data_a_q[6] && acc.wdata[6] && phase_q < PHASE_MAX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_a_q <= DATA_RESET;
			data_b_q <= DATA_RESET;
			data_c_q <= DATA_RESET;
			ctrl_a_q <= '0;
			ctrl_b_q <= '0;
			ctrl_c_q <= '0;
			tx_q[0] <= TX_0_RESET;
			tx_q[1] <= TX_1_RESET;
			tx_q[2] <= TX_2_RESET;
			sctl_q[0] <= '0;
			sctl_q[1] <= '0;
			sctl_q[2] <= '0;
			phase_q <= '0;
		end else begin
			if (do_clear) begin
				phase_q <= '0;
			end else if (phase_step) begin
				phase_q <= phase_q + 3'd1;
			end
			if (do_write) begin
				unique case (acc.offset)
					OFF_DATA_A: data_a_q <= acc.wdata;
					OFF_DATA_B: data_b_q <= acc.wdata;
					OFF_DATA_C: data_c_q <= acc.wdata;
					OFF_CTRL_A: ctrl_a_q <= acc.wdata;
					OFF_CTRL_B: ctrl_b_q <= acc.wdata;
					OFF_CTRL_C: ctrl_c_q <= acc.wdata;
					OFF_TX_0: tx_q[0] <= acc.wdata;
					OFF_TX_1: tx_q[1] <= acc.wdata;
					OFF_TX_2: tx_q[2] <= acc.wdata;
					OFF_SCTL_0: sctl_q[0] <= acc.wdata[7:3];
					OFF_SCTL_1: sctl_q[1] <= acc.wdata[7:3];
					OFF_SCTL_2: sctl_q[2] <= acc.wdata[7:3];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (acc.offset)
			OFF_VERSION: rd_mux = region_bits | VERSION_BASE;
			OFF_DATA_A: rd_mux = {data_a_q[7],
				pad_lines(buttons, data_a_q[6], six_button_mode, phase_q)};
			OFF_DATA_B: rd_mux = data_b_q | {1'b0, ~ctrl_b_q[6:0] & PORT_FILL};
			OFF_DATA_C: rd_mux = data_c_q | {1'b0, ~ctrl_c_q[6:0] & PORT_FILL};
			OFF_CTRL_A: rd_mux = ctrl_a_q;
			OFF_CTRL_B: rd_mux = ctrl_b_q;
			OFF_CTRL_C: rd_mux = ctrl_c_q;
			OFF_TX_0: rd_mux = tx_q[0];
			OFF_TX_1: rd_mux = tx_q[1];
			OFF_TX_2: rd_mux = tx_q[2];
			OFF_SCTL_0: rd_mux = {sctl_q[0], 3'b000};
			OFF_SCTL_1: rd_mux = {sctl_q[1], 3'b000};
			OFF_SCTL_2: rd_mux = {sctl_q[2], 3'b000};
			default: rd_mux = '0;
		endcase
	end

	assign read_data = (acc.op == OP_READ) ? rd_mux : '0;

	assert property (@(posedge clk) disable iff (!arst_n) phase_q <= PHASE_MAX)
		else $error("Pad phase exceeded its saturation value.");

	assert property (@(posedge clk) disable iff (!arst_n) do_clear |=> phase_q == '0)
		else $error("Pad phase not cleared after a clear request.");

	assert property (@(posedge clk) disable iff (!arst_n)
		!six_button_mode && !do_clear |=> $stable(phase_q))
		else $error("Pad phase moved in three-button mode.");

endmodule

### hdl/gamepad_io_port_controller.sv
// Top level of the gamepad I/O port controller: request handshake, config port, result register.
// A request is registered on acceptance; its result is registered when the request advances.
// Throughput: one request per cycle unless stalled; the bank and pad decode finish in one pass.
// A stalled result holds its register and the input stage, stopping new requests.
// Reset (arst_n low, asynchronous) restores the register bank defaults, clears the pad phase,
// the configuration registers and all valid flags.
module gamepad_io_port_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [3:0]  offset,
	input  logic [7:0]  write_value,
	input  logic [11:0] buttons,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data
);
	import gpc_pkg::*;

	logic        six_button_q;
	logic [7:0]  region_q;
	logic        cfg_write;
	logic        cfg_idx;

	logic        valid_s1;
	op_t         op_s1;
	logic [3:0]  offset_s1;
	logic [7:0]  wdata_s1;
	logic [11:0] buttons_s1;

	logic        out_valid_q;
	logic [7:0]  read_data_q;
	logic        advance;
	gpc_access_t acc;
	logic [7:0]  bank_rdata;

	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			six_button_q <= 1'b0;
			region_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				1'(CFG_SIX_BUTTON): six_button_q <= pwdata[0];
				1'(CFG_REGION): region_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			1'(CFG_SIX_BUTTON): prdata = {31'd0, six_button_q};
			1'(CFG_REGION): prdata = {24'd0, region_q};
			default: prdata = '0;
		endcase
	end

	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1 <= op_t'(op);
			offset_s1 <= offset;
			wdata_s1 <= write_value;
			buttons_s1 <= buttons;
		end
	end

	assign acc = '{en: advance, op: op_s1, offset: offset_s1, wdata: wdata_s1};

	gpc_regbank u_regbank (
		.clk             (clk),
		.arst_n          (arst_n),
		.acc             (acc),
		.buttons         (buttons_s1),
		.six_button_mode (six_button_q),
		.region_bits     (region_q),
		.read_data       (bank_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= bank_rdata;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("Accepted request did not reach the input stage.");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(offset_s1) && $stable(op_s1))
		else $error("Stalled request left the input stage.");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("Processed request produced no result.");

endmodule

### bench/tb_gamepad_io_port_controller.sv
// Self-checking testbench for the gamepad I/O port controller: register, pad and config traffic.
module tb_gamepad_io_port_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import gpc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int TH = 6;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_PER_SETTING = 225;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_style_t;

	class gpc_shadow;
		typedef struct {
			logic [7:0] data;
			logic [1:0] op;
			logic [3:0] offset;
		} pending_read_t;

		bit [7:0] regs [16];
		bit [2:0] phase;
		bit six_mode;
		bit [7:0] region;
		pending_read_t waiting [$];
		int errors;
		int checked;
		int accepted;
		int high_phase_reads;

		function new();
			foreach (regs[i]) regs[i] = 8'h00;
			regs[OFF_VERSION] = 8'hA0;
			regs[OFF_DATA_A] = DATA_RESET;
			regs[OFF_DATA_B] = DATA_RESET;
			regs[OFF_DATA_C] = DATA_RESET;
			regs[OFF_TX_0] = TX_0_RESET;
			regs[OFF_TX_1] = TX_1_RESET;
			regs[OFF_TX_2] = TX_2_RESET;
			phase = '0;
			six_mode = 1'b0;
			region = 8'h00;
		endfunction

		// Pad lines are active low; each mask holds the pressed buttons on their line positions.
		function bit [6:0] port_a_lines(bit [11:0] b);
			bit [5:0] hit;
			bit [5:0] base;
			if (regs[OFF_DATA_A][TH]) begin
				if (six_mode && phase == PHASE_HIGH)
					hit = {b[6], b[5], b[11], b[8], b[9], b[10]};
				else
					hit = {b[6], b[5], b[3], b[2], b[1], b[0]};
				return {1'b1, ~hit};
			end
			if (six_mode && phase == PHASE_LOW) begin
				base = 6'h30;
				hit = {b[7], b[4], 4'b0000};
			end else if (six_mode && phase == PHASE_HIGH) begin
				base = 6'h3F;
				hit = {b[7], b[4], 4'b0000};
			end else begin
				base = 6'h33;
				hit = {b[7], b[4], 2'b00, b[1], b[0]};
			end
			return {1'b0, base & ~hit};
		endfunction

		function bit [7:0] read_byte(bit [3:0] off, bit [11:0] b);
			case (off)
				OFF_VERSION: return region | VERSION_BASE;
				OFF_DATA_A: begin
					if (six_mode && phase == PHASE_HIGH)
						high_phase_reads++;
					return {regs[OFF_DATA_A][7], port_a_lines(b)};
				end
				OFF_DATA_B, OFF_DATA_C: return regs[off] | {1'b0, ~regs[off + 4'd3][6:0]};
				default: return regs[off];
			endcase
		endfunction

		function void apply_write(bit [3:0] off, bit [7:0] v);
			case (off)
				OFF_DATA_A: begin
					if (six_mode && !regs[OFF_DATA_A][TH] && v[TH] && phase < PHASE_MAX)
						phase++;
					regs[off] = v;
				end
				OFF_DATA_B, OFF_DATA_C, OFF_CTRL_A, OFF_CTRL_B, OFF_CTRL_C,
				OFF_TX_0, OFF_TX_1, OFF_TX_2: regs[off] = v;
				OFF_SCTL_0, OFF_SCTL_1, OFF_SCTL_2: regs[off] = v & 8'hF8;
				default: ;
			endcase
		endfunction

		function void note_request(logic [1:0] op, logic [3:0] off, logic [7:0] v,
			logic [11:0] b);
			pending_read_t p;
			p.op = op;
			p.offset = off;
			p.data = 8'h00;
			accepted++;
			case (op)
				OP_READ: p.data = read_byte(off, b);
				OP_WRITE: apply_write(off, v);
				OP_CLEAR: phase = '0;
				default: ;
			endcase
			waiting.push_back(p);
		endfunction

		function void check_result(logic [7:0] got);
			pending_read_t p;
			checked++;
			if (waiting.size() == 0) begin
				errors++;
				$display("%0t: read_data %02h arrived with no request outstanding", $time, got);
				return;
			end
			p = waiting.pop_front();
			if (got !== p.data) begin
				errors++;
				$display("%0t: op %0d offset %0d: read_data expected %02h, actual %02h",
					$time, p.op, p.offset, p.data, got);
			end
		endfunction

		function int pending();
			return waiting.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = OP_READ;
	logic [3:0] offset = '0;
	logic [7:0] write_value = '0;
	logic [11:0] buttons = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] read_data;

	gpc_shadow shadow;
	int cycles = 0;
	int items_sent = 0;
	int burst_left = 0;
	int config_writes = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int rx_hold = 0;
	int rx_tick = 0;
	rx_style_t rx_style = RX_OPEN;

	gamepad_io_port_controller u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.offset(offset),
		.write_value(write_value),
		.buttons(buttons),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_gamepad_io_port_controller: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				shadow.note_request(op, offset, write_value, buttons);
			if (out_valid && out_ready)
				shadow.check_result(read_data);
		end
	end

	always @(negedge clk) begin
		rx_tick++;
		if (rx_tick % 64 == 0)
			rx_style = rx_style_t'($urandom_range(0, 3));
		if (hold_served < hold_requests) begin
			hold_served++;
			rx_hold = 90;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else begin
			case (rx_style)
				RX_OPEN: out_ready <= 1'b1;
				RX_COIN: out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= (rx_tick % 4 == 0);
				default: out_ready <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	task automatic send(logic [1:0] o, logic [3:0] off, logic [7:0] v, logic [11:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		op <= o;
		offset <= off;
		write_value <= v;
		buttons <= b;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(int unsigned idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(idx * 4);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == CFG_SIX_BUTTON)
			shadow.six_mode = val[0];
		else
			shadow.region = val[7:0];
		config_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_request();
		int pick;
		logic [1:0] o;
		pick = $urandom_range(0, 15);
		if (pick < 6)
			o = OP_READ;
		else if (pick < 12)
			o = OP_WRITE;
		else if (pick < 14)
			o = OP_CLEAR;
		else
			o = OP_UNUSED;
		send(o, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
			12'($urandom_range(0, 4095)));
	endtask

	task automatic th_write(bit th_level);
		logic [7:0] v;
		v = 8'($urandom_range(0, 255));
		v[TH] = th_level;
		send(OP_WRITE, OFF_DATA_A, v, 12'($urandom_range(0, 4095)));
		if ($urandom_range(0, 3) != 0)
			send(OP_READ, OFF_DATA_A, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
	endtask

	task automatic pad_poll();
		int toggles;
		toggles = $urandom_range(1, 5);
		repeat (toggles) begin
			th_write(1'b1);
			if ($urandom_range(0, 7) == 0)
				random_request();
			th_write(1'b0);
		end
		if ($urandom_range(0, 3) != 0)
			send(OP_CLEAR, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
				12'($urandom_range(0, 4095)));
	endtask

	task automatic random_traffic(int count);
		int start;
		int kind;
		start = items_sent;
		while (items_sent - start < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 6)
				pad_poll();
			else
				random_request();
			if ($urandom_range(0, 199) == 0)
				drain();
		end
	endtask

	task automatic directed_three_button();
		send(OP_READ, OFF_VERSION, 8'h00, 12'h000);
		send(OP_WRITE, OFF_VERSION, 8'h55, 12'h000);
		send(OP_READ, OFF_VERSION, 8'hFF, 12'hFFF);
		send(OP_READ, OFF_DATA_A, 8'h00, 12'h000);
		send(OP_READ, OFF_DATA_A, 8'h00, 12'hFFF);
		send(OP_WRITE, OFF_DATA_A, 8'h80, 12'h000);
		send(OP_READ, OFF_DATA_A, 8'h00, 12'hFFF);
		send(OP_WRITE, OFF_CTRL_B, 8'hFF, 12'h000);
		send(OP_READ, OFF_DATA_B, 8'h00, 12'h000);
		send(OP_WRITE, OFF_SCTL_0, 8'hFF, 12'h000);
		send(OP_READ, OFF_SCTL_0, 8'h00, 12'h000);
		send(OP_WRITE, OFF_RX_1, 8'hFF, 12'h000);
		send(OP_READ, OFF_RX_1, 8'h00, 12'h000);
		send(OP_CLEAR, OFF_DATA_A, 8'hFF, 12'hFFF);
		send(OP_UNUSED, OFF_DATA_A, 8'hFF, 12'hFFF);
	endtask

	task automatic directed_six_button();
		send(OP_WRITE, OFF_DATA_A, 8'hC0, 12'h000);
		send(OP_WRITE, OFF_DATA_A, 8'h00, 12'h000);
		send(OP_WRITE, OFF_DATA_A, 8'h40, 12'h000);
		send(OP_READ, OFF_DATA_A, 8'h00, 12'hFFF);
		send(OP_WRITE, OFF_DATA_A, 8'h00, 12'h000);
		send(OP_READ, OFF_DATA_A, 8'h00, 12'hFFF);
		send(OP_WRITE, OFF_DATA_A, 8'h40, 12'h000);
		send(OP_READ, OFF_DATA_A, 8'h00, 12'hF00);
		send(OP_WRITE, OFF_DATA_A, 8'h00, 12'h000);
		send(OP_READ, OFF_DATA_A, 8'h00, 12'h0FF);
		send(OP_WRITE, OFF_DATA_A, 8'h40, 12'h000);
		send(OP_READ, OFF_DATA_A, 8'h00, 12'hFFF);
		send(OP_CLEAR, OFF_VERSION, 8'h00, 12'h000);
		send(OP_READ, OFF_DATA_A, 8'h00, 12'hFFF);
	endtask

	initial begin
		bit six_plan [6];
		logic [7:0] region_plan;
		six_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
		shadow = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		directed_three_button();
		drain();
		cfg_write(CFG_SIX_BUTTON, 32'd1);
		cfg_write(CFG_REGION, 32'h0000_00FF);
		directed_six_button();
		drain();
		for (int s = 0; s < 6; s++) begin
			case (s)
				0, 4: region_plan = 8'h00;
				1: region_plan = 8'hFF;
				default: region_plan = 8'($urandom_range(0, 255));
			endcase
			cfg_write(CFG_SIX_BUTTON, {31'd0, six_plan[s]});
			cfg_write(CFG_REGION, {24'd0, region_plan});
			if (s == 2)
				hold_requests++;
			random_traffic(RANDOM_PER_SETTING);
			drain();
		end
		$display("Covered %0d requests and %0d results over %0d config writes;",
			shadow.accepted, shadow.checked, config_writes);
		$display("port A was read %0d times in the high pad phase.", shadow.high_phase_reads);
		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("tb_gamepad_io_port_controller: done, clean");
		else
			$display("tb_gamepad_io_port_controller: done, errors");
		$finish;
	end

endmodule
